/* hdl/scaled_matrix_multiply_unit_assert.svh */
// Assertion macros shared by the scaled matrix multiply RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef SCALED_MATRIX_MULTIPLY_UNIT_ASSERT_SVH
`define SCALED_MATRIX_MULTIPLY_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SMM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scaled matrix multiply: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define SMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scaled matrix multiply: next-cycle check failed");

`endif

/* hdl/smm_pkg.sv */
// Shared types, codes and helper functions for the scaled matrix multiply block.
// No dependencies; used by the interfaces, smm_mac and the top module.
`default_nettype none

package smm_pkg;

    // Field and register widths.
    localparam int KIND_W      = 2;
    localparam int IDX_FIELD_W = 6;
    localparam int VALUE_W     = 16;
    localparam int PRODUCT_W   = 48;
    localparam int CNT_W       = 7;
    localparam int SCALE_W     = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int EFF_W       = 9;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_LOAD_A  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_B  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INNER_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COL_COUNT   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE       = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [CNT_W-1:0]   COUNT_RESET = 7'd64;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd6144;

    // Saturation bounds of the signed 48-bit result.
    localparam logic signed [63:0] PROD_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] PROD_MIN = -64'sh0000_8000_0000_0000;

    // Fraction width of the Q4.12 scale and low-part width of the scaling multiply.
    localparam int SCALE_FRAC = 12;
    localparam int LO_W       = 24;

    // Control from the sequencer to the accumulate and scale unit.
    typedef struct packed {
        logic clear;
        logic term_vld;
        logic term_last;
        logic res_take;
    } mac_ctl_t;

    // A count of zero acts as one; a count above the maximum acts as the maximum.
    function automatic logic [EFF_W-1:0] eff_count(input logic [CNT_W-1:0] c,
                                                   input logic [EFF_W-1:0] max_dim);
        logic [EFF_W-1:0] c_ext;
        c_ext = EFF_W'(c);
        if (c_ext == '0)
            return EFF_W'(1);
        else if (c_ext > max_dim)
            return max_dim;
        else
            return c_ext;
    endfunction

endpackage

`default_nettype wire

/* hdl/smm_if.sv */
// Valid/ready stream interfaces for the request and result words.
// Depends on smm_pkg for field widths.
`default_nettype none

// Request channel: loads of A and B elements and compute requests.
interface smm_in_if;
    logic                                      valid;
    logic                                      ready;
    logic [smm_pkg::KIND_W-1:0]                kind;
    logic [smm_pkg::IDX_FIELD_W-1:0]           row;
    logic [smm_pkg::IDX_FIELD_W-1:0]           col;
    logic signed [smm_pkg::VALUE_W-1:0]        value;

    modport source (output valid, kind, row, col, value, input ready);
    modport sink   (input valid, kind, row, col, value, output ready);
endinterface

// Result channel: one word per in-range compute request.
interface smm_out_if;
    logic                                      valid;
    logic                                      ready;
    logic [smm_pkg::IDX_FIELD_W-1:0]           out_row;
    logic [smm_pkg::IDX_FIELD_W-1:0]           out_col;
    logic signed [smm_pkg::PRODUCT_W-1:0]      product;
    logic                                      overflow;

    modport source (output valid, out_row, out_col, product, overflow, input ready);
    modport sink   (input valid, out_row, out_col, product, overflow, output ready);
endinterface

`default_nettype wire

/* hdl/smm_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module smm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output      logic [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hdl/smm_mac.sv */
// Multiply-accumulate over the inner dimension, then scale, round and saturate.
// Depends on smm_pkg for the control struct and constants.
`default_nettype none

module smm_mac #(
    parameter int ACC_W = 38
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire smm_pkg::mac_ctl_t                   ctl,
    input  wire logic signed [smm_pkg::VALUE_W-1:0]  a_data,
    input  wire logic signed [smm_pkg::VALUE_W-1:0]  b_data,
    input  wire logic [smm_pkg::SCALE_W-1:0]         scale,
    output      logic                                res_vld,
    output      logic signed [smm_pkg::PRODUCT_W-1:0] product,
    output      logic                                overflow
);

    localparam int PROD_W = 2 * smm_pkg::VALUE_W;
    localparam int LO_W   = smm_pkg::LO_W;
    localparam int HI_W   = ACC_W - LO_W;
    localparam int PLO_W  = LO_W + smm_pkg::SCALE_W;
    localparam int PHI_W  = HI_W + smm_pkg::SCALE_W + 1;
    localparam int T_W    = ACC_W + smm_pkg::SCALE_W + 1;
    localparam int Q_W    = T_W - smm_pkg::SCALE_FRAC;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     pv_reg;
    logic                     plast_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     acc_done_reg;
    logic [PLO_W-1:0]         pp_lo_reg;
    logic signed [PHI_W-1:0]  pp_hi_reg;
    logic                     pp_vld_reg;
    logic signed [T_W-1:0]    t_next;
    logic signed [Q_W-1:0]    q_reg;
    logic                     q_vld_reg;
    logic signed [63:0]       q_wide;
    logic                     sat_hi;
    logic                     sat_lo;
    logic                     res_vld_reg;
    logic signed [smm_pkg::PRODUCT_W-1:0] product_reg;
    logic                     overflow_reg;

    // Product of one A and one B element, exact Q16.16.
    always_ff @(posedge clk)
    begin
        if (ctl.term_vld)
        begin
            prod_reg <= a_data * b_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg    <= 1'b0;
            plast_reg <= 1'b0;
        end
        else
        begin
            pv_reg    <= ctl.term_vld;
            plast_reg <= ctl.term_vld & ctl.term_last;
        end
    end

    // Running sum, cleared when a compute request starts.
    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
            acc_next = '0;
        else if (pv_reg)
            acc_next = acc_reg + ACC_W'(prod_reg);
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_done_reg <= 1'b0;
        else
            acc_done_reg <= pv_reg & plast_reg;
    end

    // Scale by alpha as two partial products: low bits unsigned, high bits signed.
    always_ff @(posedge clk)
    begin
        if (acc_done_reg)
        begin
            pp_lo_reg <= PLO_W'(acc_reg[LO_W-1:0]) * PLO_W'(scale);
            pp_hi_reg <= PHI_W'($signed(acc_reg[ACC_W-1:LO_W]))
                         * PHI_W'($signed({1'b0, scale}));
        end
    end

    // Recombine, add half an LSB and drop the fraction bits (floor).
    always_comb
    begin
        t_next = (T_W'(pp_hi_reg) <<< LO_W)
                 + T_W'($signed({1'b0, pp_lo_reg}))
                 + T_W'(1 << (smm_pkg::SCALE_FRAC - 1));
    end

    always_ff @(posedge clk)
    begin
        if (pp_vld_reg)
        begin
            q_reg <= t_next[T_W-1:smm_pkg::SCALE_FRAC];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pp_vld_reg <= 1'b0;
            q_vld_reg  <= 1'b0;
        end
        else
        begin
            pp_vld_reg <= acc_done_reg;
            q_vld_reg  <= pp_vld_reg;
        end
    end

    // Saturate to the signed 48-bit range.
    always_comb
    begin
        q_wide = 64'(q_reg);
        sat_hi = (q_wide > smm_pkg::PROD_MAX);
        sat_lo = (q_wide < smm_pkg::PROD_MIN);
    end

    always_ff @(posedge clk)
    begin
        if (q_vld_reg)
        begin
            if (sat_hi)
                product_reg <= smm_pkg::PRODUCT_W'(smm_pkg::PROD_MAX);
            else if (sat_lo)
                product_reg <= smm_pkg::PRODUCT_W'(smm_pkg::PROD_MIN);
            else
                product_reg <= q_wide[smm_pkg::PRODUCT_W-1:0];
            overflow_reg <= sat_hi | sat_lo;
        end
    end

    // The result is held until the sequencer takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_vld_reg <= 1'b0;
        else if (q_vld_reg)
            res_vld_reg <= 1'b1;
        else if (ctl.res_take)
            res_vld_reg <= 1'b0;
    end

    assign res_vld  = res_vld_reg;
    assign product  = product_reg;
    assign overflow = overflow_reg;

endmodule

`default_nettype wire

/* hdl/scaled_matrix_multiply_unit.sv */
// Scaled matrix multiply C = alpha*A*B with on-chip A and B stores.
// Depends on smm_pkg, smm_if, smm_ram, smm_mac and the assertion header.
//
// Usage: request words arrive on in_ch (valid/ready). Kind 0 stores one Q8.8
// element of A at (row, col), kind 1 one element of B at (row, col); loads
// outside the configured sizes are dropped. Kind 2 asks for C[row][col]; an
// in-range request returns one word on out_ch with the position, the Q32.16
// product and an overflow flag. Kind 3 and out-of-range requests are dropped.
// Loads are accepted whenever the unit is idle. A compute request walks the
// effective inner size (a count of zero acts as one, one above MAX_DIM as
// MAX_DIM) with one A/B memory read and one multiply-accumulate per cycle.
// No word is accepted until the compute's result enters the output register.
// The stores are not cleared by reset; elements must be loaded before use.
// Reset sets the counts to 64 and alpha to 1.5 and empties the pipeline.
// The result sits in an output register: loads keep flowing while out_ch
// stalls, and a compute waits at its end until that register frees up.
// The user must write registers through cfg_we/cfg_index/cfg_data only
// while idle; the block itself does not enforce it.
`default_nettype none

`include "scaled_matrix_multiply_unit_assert.svh"

module scaled_matrix_multiply_unit #(
    parameter int MAX_DIM = 64
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [smm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [smm_pkg::CFG_DATA_W-1:0]      cfg_data,
    smm_in_if.sink                                   in_ch,
    smm_out_if.source                                out_ch
);

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int L_W    = IDX_W + 1;
    localparam int ACC_W  = 2 * smm_pkg::VALUE_W + IDX_W;
    localparam int EFF_W  = smm_pkg::EFF_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_WAIT = 3'b100
    } state_t;

    state_t                            state_reg, state_next;
    logic [smm_pkg::CNT_W-1:0]         row_count_reg;
    logic [smm_pkg::CNT_W-1:0]         inner_count_reg;
    logic [smm_pkg::CNT_W-1:0]         col_count_reg;
    logic [smm_pkg::SCALE_W-1:0]       scale_reg;
    logic [EFF_W-1:0]                  rows_eff, inner_eff, cols_eff;
    logic [EFF_W-1:0]                  row_ext, col_ext;
    logic                              accept;
    logic                              a_we, b_we;
    logic                              start_compute;
    logic [ADDR_W-1:0]                 wr_addr;
    logic [ADDR_W-1:0]                 a_raddr, b_raddr;
    logic [IDX_W-1:0]                  r_reg, c_reg;
    logic [L_W-1:0]                    l_reg, l_next;
    logic                              l_last;
    logic                              issue_vld_reg;
    logic                              issue_last_reg;
    logic [smm_pkg::VALUE_W-1:0]       a_rdata, b_rdata;
    smm_pkg::mac_ctl_t                 mac_ctl;
    logic                              mac_res_vld;
    logic signed [smm_pkg::PRODUCT_W-1:0] mac_product;
    logic                              mac_overflow;
    logic                              out_load;
    logic                              out_vld_reg;
    logic [smm_pkg::IDX_FIELD_W-1:0]   out_row_reg, out_col_reg;
    logic signed [smm_pkg::PRODUCT_W-1:0] out_product_reg;
    logic                              out_overflow_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg   <= smm_pkg::COUNT_RESET;
            inner_count_reg <= smm_pkg::COUNT_RESET;
            col_count_reg   <= smm_pkg::COUNT_RESET;
            scale_reg       <= smm_pkg::SCALE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                smm_pkg::REG_ROW_COUNT:   row_count_reg   <= cfg_data[smm_pkg::CNT_W-1:0];
                smm_pkg::REG_INNER_COUNT: inner_count_reg <= cfg_data[smm_pkg::CNT_W-1:0];
                smm_pkg::REG_COL_COUNT:   col_count_reg   <= cfg_data[smm_pkg::CNT_W-1:0];
                smm_pkg::REG_SCALE:       scale_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective sizes and range checks of the incoming word.
    always_comb
    begin
        rows_eff  = smm_pkg::eff_count(row_count_reg, EFF_W'(MAX_DIM));
        inner_eff = smm_pkg::eff_count(inner_count_reg, EFF_W'(MAX_DIM));
        cols_eff  = smm_pkg::eff_count(col_count_reg, EFF_W'(MAX_DIM));
        row_ext   = EFF_W'(in_ch.row);
        col_ext   = EFF_W'(in_ch.col);
    end

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept      = in_ch.valid & in_ch.ready;

    assign a_we = accept && (in_ch.kind == smm_pkg::KIND_LOAD_A)
                  && (row_ext < rows_eff) && (col_ext < inner_eff);
    assign b_we = accept && (in_ch.kind == smm_pkg::KIND_LOAD_B)
                  && (row_ext < inner_eff) && (col_ext < cols_eff);
    assign start_compute = accept && (in_ch.kind == smm_pkg::KIND_COMPUTE)
                  && (row_ext < rows_eff) && (col_ext < cols_eff);

    // Store addresses: row-major, row index in the upper half.
    assign wr_addr = {row_ext[IDX_W-1:0], col_ext[IDX_W-1:0]};
    assign a_raddr = {r_reg, l_reg[IDX_W-1:0]};
    assign b_raddr = {l_reg[IDX_W-1:0], c_reg};
    assign l_last  = (l_reg == L_W'(inner_eff - EFF_W'(1)));
    assign l_next  = L_W'(l_reg + L_W'(1));

    // Sequencer: idle, walk the inner index, wait for the scaled result.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start_compute)
                    state_next = S_RUN;
            end
            S_RUN:
            begin
                if (l_last)
                    state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            issue_vld_reg  <= 1'b0;
            issue_last_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_vld_reg  <= (state_reg == S_RUN);
            issue_last_reg <= (state_reg == S_RUN) & l_last;
        end
    end

    // Request position and inner index.
    always_ff @(posedge clk)
    begin
        if (start_compute)
        begin
            r_reg <= row_ext[IDX_W-1:0];
            c_reg <= col_ext[IDX_W-1:0];
            l_reg <= '0;
        end
        else if (state_reg == S_RUN)
        begin
            l_reg <= l_next;
        end
    end

    // Element stores; no writes happen while a compute reads them.
    smm_ram #(
        .WIDTH (smm_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_a_store (
        .clk   (clk),
        .we    (a_we),
        .waddr (wr_addr),
        .wdata (in_ch.value),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    smm_ram #(
        .WIDTH (smm_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_b_store (
        .clk   (clk),
        .we    (b_we),
        .waddr (wr_addr),
        .wdata (in_ch.value),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // Accumulate and scale unit.
    always_comb
    begin
        mac_ctl.clear     = start_compute;
        mac_ctl.term_vld  = issue_vld_reg;
        mac_ctl.term_last = issue_last_reg;
        mac_ctl.res_take  = out_load;
    end

    smm_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mac_ctl),
        .a_data   ($signed(a_rdata)),
        .b_data   ($signed(b_rdata)),
        .scale    (scale_reg),
        .res_vld  (mac_res_vld),
        .product  (mac_product),
        .overflow (mac_overflow)
    );

    // Output register: loads when empty or when the current word leaves.
    assign out_load = (state_reg == S_WAIT) && mac_res_vld
                      && (!out_vld_reg || out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (out_load)
            out_vld_reg <= 1'b1;
        else if (out_ch.ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_row_reg      <= smm_pkg::IDX_FIELD_W'(r_reg);
            out_col_reg      <= smm_pkg::IDX_FIELD_W'(c_reg);
            out_product_reg  <= mac_product;
            out_overflow_reg <= mac_overflow;
        end
    end

    assign out_ch.valid    = out_vld_reg;
    assign out_ch.out_row  = out_row_reg;
    assign out_ch.out_col  = out_col_reg;
    assign out_ch.product  = out_product_reg;
    assign out_ch.overflow = out_overflow_reg;

    // Checks on the sequencer and the store ports.
    `SMM_ASSERT_IMPL(a_no_write_busy, clk, rst_n, state_reg != S_IDLE, !(a_we || b_we))
    `SMM_ASSERT_IMPL(a_res_in_wait, clk, rst_n, mac_res_vld, state_reg == S_WAIT)
    `SMM_ASSERT_NEXT(a_start_run, clk, rst_n, start_compute, (state_reg == S_RUN) && (l_reg == '0))
    `SMM_ASSERT_IMPL(a_take_has_res, clk, rst_n, mac_ctl.res_take, mac_res_vld)

endmodule

`default_nettype wire
